// File: rtl/core/caes_pkg.sv
// Shared types and constants for the closest-atom-of-element search block.
// Holds the command and status codes, the controller state type and fixed field widths.
// No dependencies.
package caes_pkg;

	localparam int CMD_W    = 2;
	localparam int POS_W    = 16;
	localparam int ELEM_W   = 7;
	localparam int STATUS_W = 2;
	localparam int IDX_W    = 6;
	localparam int DIST_W   = 34;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_NOMATCH = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} ctrl_state_t;

endpackage

// File: rtl/core/closest_atom_of_element_search.sv
// Top level of the closest-atom-of-element search: atom store, scan pipeline and control.
// Depends on caes_pkg for codes, widths and the controller state type.
//
// Usage:
//   Input beats (in_valid/in_ready) carry a command with a position and an element.
//   CMD_CLEAR empties the store, CMD_APPEND stores one atom and returns its index
//   (status ST_FULL when the store already holds MAX_ATOMS atoms), CMD_QUERY returns
//   the index and squared distance of the nearest stored atom of the given element,
//   the lowest index winning ties, or status ST_NOMATCH with found low.
//   Every input beat produces exactly one output beat (out_valid/out_ready).
// Command flow:
//   The block works on one command at a time. A clear, an append, an unused command or
//   a query of an empty store goes from acceptance through S_FINISH into the output
//   register, and the next beat is taken once the block is back in S_IDLE. A query
//   reads one stored atom per cycle from the atom memory's single read port: atom_count
//   reads, four pipeline stages (difference, square, sum, compare), then the result is
//   latched as pending and loaded into the output register before the next beat is taken.
// Reset and stalls:
//   Reset empties the store (the atom count goes to zero) and drops out_valid.
//   The result sits in an output register; while the receiver stalls, the next
//   command is still accepted and processed, and only its own hand-over waits
//   until the output register is free.
module closest_atom_of_element_search
	import caes_pkg::*;
#(
	parameter int MAX_ATOMS  = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [POS_W-1:0]    pos_x,
	input  logic [POS_W-1:0]    pos_y,
	input  logic [POS_W-1:0]    pos_z,
	input  logic [ELEM_W-1:0]   element,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic                found,
	output logic [IDX_W-1:0]    atom_index,
	output logic [DIST_W-1:0]   best_distance_sq
);

	localparam int AW     = $clog2(MAX_ATOMS);
	localparam int CW     = $clog2(MAX_ATOMS + 1);
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int SUM_W  = SQ_W + 2;
	localparam int WORD_W = ELEM_W + 3 * COORD_BITS;

	// Memory word layout: {element, x, y, z}.
	localparam int Z_LO = 0;
	localparam int Y_LO = COORD_BITS;
	localparam int X_LO = 2 * COORD_BITS;
	localparam int E_LO = 3 * COORD_BITS;

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
		abs_diff = d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
	endfunction

	ctrl_state_t state_q, state_nxt;

	logic [COORD_BITS-1:0] in_x, in_y, in_z;
	logic                  accept;
	logic                  scan_issue, scan_last, pipe_empty, drain_done, finish_go;
	logic                  store_full;

	logic [CW-1:0]         count_q;
	logic [AW-1:0]         scan_addr_q;
	logic [COORD_BITS-1:0] qx_q, qy_q, qz_q;
	logic [ELEM_W-1:0]     qelem_q;

	logic [WORD_W-1:0]     mem [MAX_ATOMS];

	// Scan pipeline.
	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	logic [AW-1:0]         idx_s1, idx_s2, idx_s3, idx_s4;
	logic [WORD_W-1:0]     word_s1;
	logic                  match_s2, match_s3, match_s4;
	logic [COORD_BITS-1:0] mag_x_s2, mag_y_s2, mag_z_s2;
	logic [SQ_W-1:0]       sq_x_s3, sq_y_s3, sq_z_s3;
	logic [SUM_W-1:0]      sum_s4;

	logic                  have_q;
	logic [SUM_W-1:0]      best_q;
	logic [AW-1:0]         best_idx_q;
	logic [DIST_W-1:0]     dist_sat;

	// Pending result, waiting for the output register.
	logic [STATUS_W-1:0]   res_status_q;
	logic                  res_found_q;
	logic [IDX_W-1:0]      res_idx_q;
	logic [DIST_W-1:0]     res_dist_q;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic                  found_q;
	logic [IDX_W-1:0]      atom_index_q;
	logic [DIST_W-1:0]     best_distance_sq_q;

	// Coordinates take the low COORD_BITS bits of the field as two's complement.
	// A wider coordinate sees the 16-bit field as a non-negative value.
	generate
		if (COORD_BITS <= POS_W) begin : g_coord_narrow
			assign in_x = pos_x[COORD_BITS-1:0];
			assign in_y = pos_y[COORD_BITS-1:0];
			assign in_z = pos_z[COORD_BITS-1:0];
		end else begin : g_coord_wide
			assign in_x = {{(COORD_BITS - POS_W){1'b0}}, pos_x};
			assign in_y = {{(COORD_BITS - POS_W){1'b0}}, pos_y};
			assign in_z = {{(COORD_BITS - POS_W){1'b0}}, pos_z};
		end
	endgenerate

	// Distances beyond the result width saturate to all ones.
	generate
		if (SUM_W > DIST_W) begin : g_dist_sat
			assign dist_sat = (|best_q[SUM_W-1:DIST_W]) ? {DIST_W{1'b1}}
			                                          : best_q[DIST_W-1:0];
		end else begin : g_dist_ext
			assign dist_sat = DIST_W'(best_q);
		end
	endgenerate

	assign accept     = in_valid && in_ready;
	assign store_full = (count_q == CW'(MAX_ATOMS));
	assign scan_last  = (CW'(scan_addr_q) == count_q - CW'(1));
	assign pipe_empty = !(vld_s1 || vld_s2 || vld_s3 || vld_s4);

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_QUERY && count_q != '0) begin
						state_nxt = S_SCAN;
					end else begin
						state_nxt = S_FINISH;
					end
				end
			end
			S_SCAN: begin
				if (scan_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (pipe_empty) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		in_ready   = 1'b0;
		scan_issue = 1'b0;
		drain_done = 1'b0;
		finish_go  = 1'b0;
		case (state_q)
			S_IDLE:   in_ready   = 1'b1;
			S_SCAN:   scan_issue = 1'b1;
			S_DRAIN:  drain_done = pipe_empty;
			S_FINISH: finish_go  = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Atom count: cleared by a clear command, bumped by a successful append.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (cmd == CMD_CLEAR) begin
				count_q <= '0;
			end else if (cmd == CMD_APPEND && !store_full) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// Atom memory: one write port for appends, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_APPEND && !store_full) begin
			mem[count_q[AW-1:0]] <= {element, in_x, in_y, in_z};
		end
		word_s1 <= mem[scan_addr_q];
	end

	// Query point and scan address.
	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q        <= in_x;
			qy_q        <= in_y;
			qz_q        <= in_z;
			qelem_q     <= element;
			scan_addr_q <= '0;
		end else if (scan_issue) begin
			scan_addr_q <= scan_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= scan_issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Datapath: absolute differences, squares, sum.
	always_ff @(posedge clk) begin
		idx_s1   <= scan_addr_q;

		idx_s2   <= idx_s1;
		match_s2 <= (word_s1[E_LO +: ELEM_W] == qelem_q);
		mag_x_s2 <= abs_diff(word_s1[X_LO +: COORD_BITS], qx_q);
		mag_y_s2 <= abs_diff(word_s1[Y_LO +: COORD_BITS], qy_q);
		mag_z_s2 <= abs_diff(word_s1[Z_LO +: COORD_BITS], qz_q);

		idx_s3   <= idx_s2;
		match_s3 <= match_s2;
		sq_x_s3  <= SQ_W'(mag_x_s2) * SQ_W'(mag_x_s2);
		sq_y_s3  <= SQ_W'(mag_y_s2) * SQ_W'(mag_y_s2);
		sq_z_s3  <= SQ_W'(mag_z_s2) * SQ_W'(mag_z_s2);

		idx_s4   <= idx_s3;
		match_s4 <= match_s3;
		sum_s4   <= SUM_W'(sq_x_s3) + SUM_W'(sq_y_s3) + SUM_W'(sq_z_s3);
	end

	// Running best: only a strictly smaller distance replaces it, so ties keep
	// the lower index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (accept) begin
			have_q <= 1'b0;
		end else if (vld_s4 && match_s4) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s4 && match_s4 && (!have_q || sum_s4 < best_q)) begin
			best_q     <= sum_s4;
			best_idx_q <= idx_s4;
		end
	end

	// Pending result: set on acceptance for every command (a query as no match),
	// and set again when a query scan has drained.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= ST_OK;
			res_found_q  <= 1'b0;
			res_idx_q    <= '0;
			res_dist_q   <= '0;
			case (cmd)
				CMD_APPEND: begin
					if (store_full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_idx_q <= IDX_W'(count_q);
					end
				end
				CMD_QUERY: res_status_q <= ST_NOMATCH;
				default: ;
			endcase
		end else if (drain_done) begin
			res_status_q <= have_q ? ST_OK : ST_NOMATCH;
			res_found_q  <= have_q;
			res_idx_q    <= have_q ? IDX_W'(best_idx_q) : '0;
			res_dist_q   <= have_q ? dist_sat : '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			status_q           <= res_status_q;
			found_q            <= res_found_q;
			atom_index_q       <= res_idx_q;
			best_distance_sq_q <= res_dist_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign found            = found_q;
	assign atom_index       = atom_index_q;
	assign best_distance_sq = best_distance_sq_q;

	// The scan pipeline is empty whenever a new command can be taken.
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> pipe_empty)
		else $error("scan pipeline busy while idle");

	// The atom count never passes the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ATOMS))
		else $error("atom count beyond store depth");

	// Each scan read shows up in the first pipeline stage in the following cycle.
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		scan_issue |=> vld_s1)
		else $error("scan read lost");

	// Compare-stage activity happens only while a query is scanning or draining.
	a_compare_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (state_q == S_SCAN || state_q == S_DRAIN))
		else $error("compare stage active outside a query");

	// A found result always carries status ok.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> status_q == ST_OK)
		else $error("found with non-ok status");

endmodule

// File: verif/closest_atom_of_element_search_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for closest_atom_of_element_search: clear, append and query beats.
// Depends on caes_pkg and on the block's RTL; carries its own model of the atom store.
module closest_atom_of_element_search_test;
	import caes_pkg::*;

	localparam int STORE_DEPTH = 64;
	localparam int PLANNED_BEATS = 1900;
	localparam int SETTLE_CYCLES = 100;
	localparam int PRINT_LIMIT = 30;
	localparam logic [POS_W-1:0] POS_MIN = 16'h8000;
	localparam logic [POS_W-1:0] POS_MAX = 16'h7FFF;
	localparam longint DIST_ALL_ONES = (longint'(1) << DIST_W) - 1;

	// One command beat as the sender presents it. A beat marked drain_first is held
	// back until every result of the earlier beats has come out.
	typedef struct {
		cmd_t              op;
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [POS_W-1:0]  z;
		logic [ELEM_W-1:0] el;
		bit                drain_first;
	} command_beat_t;

	// The result fields the block must return for one command beat.
	typedef struct packed {
		status_t          status;
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [DIST_W-1:0] dist_sq;
	} search_answer_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    cmd = CMD_CLEAR;
	logic [POS_W-1:0]    pos_x = '0;
	logic [POS_W-1:0]    pos_y = '0;
	logic [POS_W-1:0]    pos_z = '0;
	logic [ELEM_W-1:0]   element = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [IDX_W-1:0]    atom_index;
	logic [DIST_W-1:0]   best_distance_sq;

	// Our own copy of the atom store and its fill level.
	logic signed [POS_W-1:0] atom_x [STORE_DEPTH];
	logic signed [POS_W-1:0] atom_y [STORE_DEPTH];
	logic signed [POS_W-1:0] atom_z [STORE_DEPTH];
	logic [ELEM_W-1:0]       atom_el [STORE_DEPTH];
	int                      atoms_held = 0;

	command_beat_t  beats_to_send [$];
	search_answer_t answers_due [$];
	int             beats_planned = 0;
	int             beats_sent = 0;
	int             results_back = 0;
	int             results_checked = 0;
	int             mismatches = 0;

	closest_atom_of_element_search #(
		.MAX_ATOMS(STORE_DEPTH),
		.COORD_BITS(POS_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.element(element),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.found(found),
		.atom_index(atom_index),
		.best_distance_sq(best_distance_sq)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Applies one command to the local store and returns the answer the block owes for it.
	// A query walks the held atoms in index order; only a strictly smaller distance
	// replaces the best so far, so the lowest index wins a tie.
	function automatic search_answer_t nearest_atom_answer(input cmd_t op,
			input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
			input logic signed [POS_W-1:0] z, input logic [ELEM_W-1:0] el);
		search_answer_t ans;
		longint dx, dy, dz, d, best;
		int best_at;
		bit have;
		ans.status = ST_OK;
		ans.found = 1'b0;
		ans.idx = '0;
		ans.dist_sq = '0;
		have = 1'b0;
		best = 0;
		best_at = 0;
		case (op)
			CMD_CLEAR: begin
				atoms_held = 0;
			end
			CMD_APPEND: begin
				if (atoms_held >= STORE_DEPTH) begin
					ans.status = ST_FULL;
				end else begin
					atom_x[atoms_held] = x;
					atom_y[atoms_held] = y;
					atom_z[atoms_held] = z;
					atom_el[atoms_held] = el;
					ans.idx = IDX_W'(atoms_held);
					atoms_held++;
				end
			end
			CMD_QUERY: begin
				for (int i = 0; i < atoms_held; i++) begin
					if (atom_el[i] == el) begin
						dx = longint'(atom_x[i]) - longint'(x);
						dy = longint'(atom_y[i]) - longint'(y);
						dz = longint'(atom_z[i]) - longint'(z);
						d = dx * dx + dy * dy + dz * dz;
						if (!have || d < best) begin
							have = 1'b1;
							best = d;
							best_at = i;
						end
					end
				end
				if (have) begin
					ans.found = 1'b1;
					ans.idx = IDX_W'(best_at);
					ans.dist_sq = (best > DIST_ALL_ONES) ? DIST_W'(DIST_ALL_ONES)
						: DIST_W'(best);
				end else begin
					ans.status = ST_NOMATCH;
				end
			end
			default: begin
				// The unused command leaves the store alone and answers all zeros.
			end
		endcase
		return ans;
	endfunction

	task automatic report_mismatch(input string what, input int beat_no,
			input longint unsigned got, input longint unsigned want);
		if (mismatches < PRINT_LIMIT)
			$display("result %0d: %s is 0x%0h, expected 0x%0h", beat_no, what, got, want);
		mismatches++;
	endtask

	task automatic add_beat(input cmd_t op, input logic [POS_W-1:0] x,
			input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
			input logic [ELEM_W-1:0] el, input bit drain_first);
		command_beat_t b;
		b.op = op;
		b.x = x;
		b.y = y;
		b.z = z;
		b.el = el;
		b.drain_first = drain_first;
		beats_to_send.insert(beats_to_send.size(), b);
		// The unused command leaves the block's store alone, so it does not count as work.
		if (op != CMD_NONE)
			beats_planned++;
	endtask

	// Layout 1 packs atoms into a tiny cube so that equal distances (ties) are common,
	// layout 2 favors the extremes, zero and minus one of the coordinate range, anything else is uniform.
	function automatic logic [POS_W-1:0] pick_coord(input int layout);
		case (layout)
			1: return POS_W'($urandom_range(0, 8) - 4);
			2: begin
				case ($urandom_range(0, 4))
					0: return POS_MIN;
					1: return POS_MAX;
					2: return '0;
					3: return '1;
					default: return POS_W'($urandom);
				endcase
			end
			default: return POS_W'($urandom);
		endcase
	endfunction

	initial begin : build_stimulus
		logic [ELEM_W-1:0] kinds [4];
		logic [ELEM_W-1:0] el;
		int layout, n_kinds, n_atoms, n_queries;
		bit first_seq;

		// Directed opening: empty-store query, unused command, corner coordinates with
		// the largest possible distance, a query with no match, a three-way tie and
		// a query right after a clear.
		add_beat(CMD_QUERY, '0, '0, '0, 7'd0, 1'b0);
		add_beat(CMD_NONE, POS_MAX, POS_MIN, '1, 7'd127, 1'b0);
		add_beat(CMD_APPEND, POS_MIN, POS_MIN, POS_MIN, 7'd127, 1'b0);
		add_beat(CMD_APPEND, POS_MAX, POS_MAX, POS_MAX, 7'd0, 1'b0);
		add_beat(CMD_QUERY, POS_MAX, POS_MAX, POS_MAX, 7'd127, 1'b0);
		add_beat(CMD_QUERY, POS_MIN, POS_MIN, POS_MIN, 7'd0, 1'b0);
		add_beat(CMD_QUERY, POS_MIN, POS_MIN, POS_MIN, 7'd127, 1'b0);
		add_beat(CMD_QUERY, '0, '0, '0, 7'd64, 1'b0);
		add_beat(CMD_APPEND, 16'd2, '0, '0, 7'd5, 1'b0);
		add_beat(CMD_APPEND, 16'hFFFE, '0, '0, 7'd5, 1'b0);
		add_beat(CMD_APPEND, '0, '0, 16'd2, 7'd5, 1'b0);
		add_beat(CMD_QUERY, '0, '0, '0, 7'd5, 1'b0);
		add_beat(CMD_NONE, pick_coord(0), pick_coord(0), pick_coord(0), 7'($urandom), 1'b0);
		add_beat(CMD_QUERY, 16'd1, '0, '0, 7'd5, 1'b0);
		add_beat(CMD_CLEAR, '0, '0, '0, '0, 1'b0);
		add_beat(CMD_QUERY, '0, '0, '0, 7'd127, 1'b0);
		add_beat(CMD_APPEND, '1, '1, '1, 7'd127, 1'b0);
		add_beat(CMD_QUERY, '0, '0, '0, 7'd127, 1'b0);

		// Random part: mostly fill-then-query sequences over a small set of elements,
		// now and then run past a full store, mixed with bursts of raw noise.
		first_seq = 1'b1;
		while (beats_planned < PLANNED_BEATS) begin
			if (!first_seq && $urandom_range(0, 99) < 10) begin
				repeat ($urandom_range(1, 4))
					add_beat(cmd_t'($urandom_range(0, 3)), pick_coord(0), pick_coord(0),
						pick_coord(0), 7'($urandom), 1'b0);
			end else begin
				layout = $urandom_range(0, 2);
				n_kinds = $urandom_range(1, 4);
				for (int k = 0; k < 4; k++)
					kinds[k] = 7'($urandom);
				n_atoms = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70)
					: $urandom_range(1, 16);
				n_queries = $urandom_range(2, 10);
				// Leaving out the clear stacks the new atoms on top of the old ones.
				// The first sequence always opens with a clear that waits for a drain.
				if (first_seq || $urandom_range(0, 4) != 0)
					add_beat(CMD_CLEAR, pick_coord(0), pick_coord(0), pick_coord(0),
						7'($urandom), first_seq || $urandom_range(0, 24) == 0);
				for (int a = 0; a < n_atoms; a++)
					add_beat(CMD_APPEND, pick_coord(layout), pick_coord(layout),
						pick_coord(layout), kinds[$urandom_range(0, n_kinds - 1)], 1'b0);
				for (int q = 0; q < n_queries; q++) begin
					el = ($urandom_range(0, 5) == 0) ? 7'($urandom)
						: kinds[$urandom_range(0, n_kinds - 1)];
					add_beat(CMD_QUERY, pick_coord(layout), pick_coord(layout),
						pick_coord(layout), el, 1'b0);
				end
				first_seq = 1'b0;
			end
		end
	end

	// Sender. The expected answer is worked out at the edge where a beat is accepted.
	// Results are counted here as well, so that the drain check before a held beat
	// does not depend on the order in which the two clocked blocks run.
	always @(posedge clk or negedge arst_n) begin : sender
		command_beat_t nxt;
		bit launch;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= CMD_CLEAR;
			pos_x <= '0;
			pos_y <= '0;
			pos_z <= '0;
			element <= '0;
			beats_sent = 0;
			results_back = 0;
		end else begin
			if (in_valid && in_ready) begin
				answers_due.insert(answers_due.size(),
					nearest_atom_answer(cmd_t'(cmd), pos_x, pos_y, pos_z, element));
				beats_sent++;
			end
			if (out_valid && out_ready)
				results_back++;
			// A new beat may only be offered once the current one is gone; valid
			// is never pulled back while a beat waits for ready.
			if (!in_valid || in_ready) begin
				launch = beats_to_send.size() > 0 &&
					((beats_sent >= 700 && beats_sent < 1000) || $urandom_range(0, 99) >= 22);
				if (launch && beats_to_send[0].drain_first && beats_sent != results_back)
					launch = 1'b0;
				if (launch) begin
					nxt = beats_to_send.pop_front();
					cmd <= nxt.op;
					pos_x <= nxt.x;
					pos_y <= nxt.y;
					pos_z <= nxt.z;
					element <= nxt.el;
				end
				in_valid <= launch;
			end
		end
	end

	// Receiver. Every accepted result is matched against the oldest answer due; the
	// ready line idles at random except in a quiet window in the middle of the run.
	always @(posedge clk or negedge arst_n) begin : receiver
		search_answer_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			results_checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answers_due.size() == 0) begin
					report_mismatch("result with none due, status", results_checked,
						status, 0);
				end else begin
					want = answers_due.pop_front();
					if (status !== want.status)
						report_mismatch("status", results_checked, status, want.status);
					if (found !== want.found)
						report_mismatch("found", results_checked, found, want.found);
					if (atom_index !== want.idx)
						report_mismatch("atom_index", results_checked, atom_index, want.idx);
					if (best_distance_sq !== want.dist_sq)
						report_mismatch("best_distance_sq", results_checked,
							best_distance_sq, want.dist_sq);
				end
				results_checked++;
			end
			out_ready <= (results_checked >= 700 && results_checked < 1000) ||
				$urandom_range(0, 99) >= 22;
		end
	end

	// Reset once, then wait until every beat is sent and answered, and give the block
	// time for a full-store query more so that a stray extra result would show up.
	initial begin : run_control
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (beats_to_send.size() != 0 || in_valid || answers_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("closest_atom_of_element_search_test passed");
		end else begin
			$display("closest_atom_of_element_search_test failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin : watchdog
		#8_000_000;
		$display("closest_atom_of_element_search_test failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/caes_pkg.sv
rtl/core/closest_atom_of_element_search.sv
verif/closest_atom_of_element_search_test.sv
